[hdl/assert_macros.svh]
// assertion macros shared by the deframer rtl
// included by files that carry concurrent assertions; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/wsd_pkg.sv]
// types and constants of the websocket deframer
// no dependencies; imported by the front, queue, back and top level
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] LEN_EXT16 = 7'h7e;
    localparam logic [6:0] LEN_EXT64 = 7'h7f;
    localparam logic [3:0] OP_CONT   = 4'h0;

    // last header count value of each multi-byte header field
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_ZERO_LEN = 2'd1;
    localparam logic [1:0] ERR_OPCODE   = 2'd2;

    // one classified result waiting for the back end
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key_byte;
        logic       mask_on;
        logic [3:0] opcode;
        logic       frame_end;
        logic       message_end;
        logic [1:0] err;
    } t_item;

endpackage

[hdl/websocket_frame_deframer_core.sv]
// WebSocket receive deframer: takes one stream byte per cycle and delivers one
// unmasked payload byte per payload input byte, with message opcode, frame-end and
// message-end marks; a zero-length frame or an opcode mismatch between fragments
// gives one error transfer, after which input is taken and dropped until reset.
// Header bytes give no output. One byte is accepted every cycle while the sink
// keeps up; each result passes from the parser into a four-entry queue and then
// into the output register, and the input stalls only when that queue is full.
// Only the low LENGTH_BITS bits of an extended length are kept. No clearing
// pass after reset. Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module websocket_frame_deframer_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_payload_byte,
    output logic [3:0] o_msg_opcode,
    output logic       o_frame_end,
    output logic       o_message_end,
    output logic [1:0] o_error_code
);
    import wsd_pkg::*;

    logic              q_full;
    logic              q_valid;
    logic              push;
    logic              pop;
    t_item             push_item;
    t_item             head_item;
    logic [QCNT_W-1:0] q_count;

    wsd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_in_byte(i_in_byte),
        .i_full   (q_full),
        .o_stall  (o_stall),
        .o_push   (push),
        .o_item   (push_item)
    );

    wsd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (push_item),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_item (head_item),
        .o_count(q_count)
    );

    wsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_item        (head_item),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_payload_byte(o_payload_byte),
        .o_msg_opcode  (o_msg_opcode),
        .o_frame_end   (o_frame_end),
        .o_message_end (o_message_end),
        .o_error_code  (o_error_code)
    );

    `ASSERT_IMPLIES(a_queue_bound, i_clk, i_rst_n, 1'b1, q_count <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
    `ASSERT_IMPLIES(a_error_clean, i_clk, i_rst_n, o_valid && (o_error_code != ERR_NONE), (o_payload_byte == 8'h00) && (o_msg_opcode == 4'h0) && !o_frame_end && !o_message_end, "error transfer carries payload fields")
    `ASSERT_IMPLIES(a_msg_in_frame, i_clk, i_rst_n, o_valid && o_message_end, o_frame_end, "message end without frame end")
    `ASSERT_NEXT(a_dead_after_err, i_clk, i_rst_n, push && (push_item.err != ERR_NONE), !push, "item queued after an error")

endmodule

[hdl/wsd_front.sv]
// header parser: walks the frame header and turns payload bytes into queue items
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_front #(
    parameter int LENGTH_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_in_byte,
    input  logic           i_full,
    output logic           o_stall,
    output logic           o_push,
    output wsd_pkg::t_item o_item
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_FLAGS,
        PH_LEN,
        PH_EXT16,
        PH_EXT64,
        PH_KEY,
        PH_PAYLOAD,
        PH_DEAD
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_hdr_cnt, n_hdr_cnt;
    logic [LENGTH_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [31:0]            r_mask_key, n_mask_key;
    logic                   r_mask_on, n_mask_on;
    logic [1:0]             r_mask_phase, n_mask_phase;
    logic                   r_fin, n_fin;
    logic [3:0]             r_msg_type, n_msg_type;

    logic                   accept;
    logic                   len_done;
    logic [LENGTH_BITS-1:0] len_val;
    logic [LENGTH_BITS+7:0] len_shift;
    logic [LENGTH_BITS-1:0] dec;
    logic [7:0]             key_sel;
    logic [3:0]             op;
    logic                   last;

    assign o_stall   = i_full;
    assign accept    = i_valid && !i_full;
    assign len_shift = {r_bytes_left, i_in_byte};
    assign dec       = r_bytes_left - LENGTH_BITS'(1);
    assign op        = i_in_byte[3:0];
    assign last      = (dec == '0);

    always_comb begin
        case (r_mask_phase)
            2'd0:    key_sel = r_mask_key[31:24];
            2'd1:    key_sel = r_mask_key[23:16];
            2'd2:    key_sel = r_mask_key[15:8];
            default: key_sel = r_mask_key[7:0];
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_bytes_left = r_bytes_left;
        n_mask_key   = r_mask_key;
        n_mask_on    = r_mask_on;
        n_mask_phase = r_mask_phase;
        n_fin        = r_fin;
        n_msg_type   = r_msg_type;
        o_push       = 1'b0;
        o_item       = '0;
        len_done     = 1'b0;
        len_val      = '0;

        if (accept) begin
            case (r_phase)
                PH_FLAGS: begin
                    n_fin = i_in_byte[7];
                    if (r_msg_type == OP_CONT) begin
                        n_msg_type = op;
                        n_phase    = PH_LEN;
                    end else if (op != r_msg_type && op != OP_CONT) begin
                        o_push     = 1'b1;
                        o_item.err = ERR_OPCODE;
                        n_phase    = PH_DEAD;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_mask_on  = i_in_byte[7];
                    n_mask_key = '0;
                    n_hdr_cnt  = '0;
                    if (i_in_byte[6:0] == LEN_EXT16) begin
                        n_bytes_left = '0;
                        n_phase      = PH_EXT16;
                    end else if (i_in_byte[6:0] == LEN_EXT64) begin
                        n_bytes_left = '0;
                        n_phase      = PH_EXT64;
                    end else begin
                        len_done = 1'b1;
                        len_val  = LENGTH_BITS'(i_in_byte[6:0]);
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    n_bytes_left = len_shift[LENGTH_BITS-1:0];
                    if (r_hdr_cnt == ((r_phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
                        len_done = 1'b1;
                        len_val  = len_shift[LENGTH_BITS-1:0];
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                    end
                end
                PH_KEY: begin
                    n_mask_key = {r_mask_key[23:0], i_in_byte};
                    if (r_hdr_cnt == KEY_LAST) begin
                        n_hdr_cnt = '0;
                        n_phase   = PH_PAYLOAD;
                    end else begin
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                    end
                end
                PH_PAYLOAD: begin
                    n_bytes_left       = dec;
                    n_mask_phase       = r_mask_phase + 2'd1;
                    o_push             = 1'b1;
                    o_item.data        = i_in_byte;
                    o_item.key_byte    = key_sel;
                    o_item.mask_on     = r_mask_on;
                    o_item.opcode      = r_msg_type;
                    o_item.frame_end   = last;
                    o_item.message_end = last && r_fin;
                    o_item.err         = ERR_NONE;
                    if (last) begin
                        n_phase = PH_FLAGS;
                        if (r_fin) begin
                            n_msg_type = OP_CONT;
                        end
                    end
                end
                PH_DEAD: begin
                    n_phase = PH_DEAD;
                end
                default: begin
                    n_phase = PH_DEAD;
                end
            endcase

            // length complete: zero length is fatal, else key or payload next
            if (len_done) begin
                n_bytes_left = len_val;
                n_hdr_cnt    = '0;
                n_mask_phase = '0;
                if (len_val == '0) begin
                    o_push     = 1'b1;
                    o_item     = '0;
                    o_item.err = ERR_ZERO_LEN;
                    n_phase    = PH_DEAD;
                end else begin
                    n_phase = n_mask_on ? PH_KEY : PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FLAGS;
            r_hdr_cnt    <= '0;
            r_bytes_left <= '0;
            r_mask_key   <= '0;
            r_mask_on    <= 1'b0;
            r_mask_phase <= '0;
            r_fin        <= 1'b0;
            r_msg_type   <= '0;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_bytes_left <= n_bytes_left;
            r_mask_key   <= n_mask_key;
            r_mask_on    <= n_mask_on;
            r_mask_phase <= n_mask_phase;
            r_fin        <= n_fin;
            r_msg_type   <= n_msg_type;
        end
    end

endmodule

[hdl/wsd_queue.sv]
// short fifo between the header parser and the output stage
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  wsd_pkg::t_item        i_item,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output wsd_pkg::t_item        o_item,
    output logic [wsd_pkg::QCNT_W-1:0] o_count
);
    import wsd_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/wsd_back.sv]
// output stage: applies the mask and holds the result register toward the sink
// depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  wsd_pkg::t_item i_item,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [7:0]     o_payload_byte,
    output logic [3:0]     o_msg_opcode,
    output logic           o_frame_end,
    output logic           o_message_end,
    output logic [1:0]     o_error_code
);
    import wsd_pkg::*;

    logic       r_valid;
    logic [7:0] r_payload;
    logic [3:0] r_opcode;
    logic       r_frame_end;
    logic       r_message_end;
    logic [1:0] r_err;
    logic [7:0] n_payload;

    // load a new transfer whenever the register is empty or being taken
    assign o_pop     = i_q_valid && (!r_valid || !i_stall);
    assign n_payload = i_item.mask_on ? (i_item.data ^ i_item.key_byte) : i_item.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_payload     <= n_payload;
            r_opcode      <= i_item.opcode;
            r_frame_end   <= i_item.frame_end;
            r_message_end <= i_item.message_end;
            r_err         <= i_item.err;
        end
    end

    assign o_valid        = r_valid;
    assign o_payload_byte = r_payload;
    assign o_msg_opcode   = r_opcode;
    assign o_frame_end    = r_frame_end;
    assign o_message_end  = r_message_end;
    assign o_error_code   = r_err;

endmodule
